// ===== rtl/core/mh_pkg.sv =====
// shared types, constants and the arctangent table for the magnetometer heading block
package mh_pkg;

  // cordic depth and fixed-point layout
  localparam int unsigned CORDIC_STAGES = 18;
  localparam int unsigned TAB_LEN       = 24;
  localparam int unsigned PRESHIFT      = 20;
  localparam int unsigned MAG_W         = 17;
  localparam int unsigned CW            = MAG_W + PRESHIFT + 4;
  localparam int unsigned ANG_W         = 25;
  localparam int unsigned ZC_W          = 23;
  localparam int unsigned CENTI_W       = 14;

  // angle and heading constants
  localparam logic [ZC_W-1:0] QUARTER_Z = 23'd5898240;
  localparam logic [15:0] FULL_TURN     = 16'd36000;
  localparam logic [15:0] BASE_WEST     = 16'd9000;
  localparam logic [15:0] BASE_EAST     = 16'd27000;

  // sector thresholds in hundredths of a degree
  localparam logic [15:0] TH_N_HI = 16'd33750;
  localparam logic [15:0] TH_N_LO = 16'd2250;
  localparam logic [15:0] TH_NW   = 16'd29250;
  localparam logic [15:0] TH_W    = 16'd24750;
  localparam logic [15:0] TH_SW   = 16'd20250;
  localparam logic [15:0] TH_S    = 16'd15750;
  localparam logic [15:0] TH_SE   = 16'd11250;
  localparam logic [15:0] TH_E    = 16'd6750;

  typedef logic        [MAG_W-1:0] mag_t;
  typedef logic signed [CW-1:0]    cw_t;
  typedef logic signed [ANG_W-1:0] ang_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_OFFSET_SUM_X = 2'd0,
    CFG_OFFSET_SUM_Y = 2'd1,
    CFG_DECLINATION  = 2'd2
  } cfg_idx_t;

  // compass sectors
  typedef enum logic [2:0] {
    DIR_N  = 3'd0,
    DIR_NE = 3'd1,
    DIR_E  = 3'd2,
    DIR_SE = 3'd3,
    DIR_S  = 3'd4,
    DIR_SW = 3'd5,
    DIR_W  = 3'd6,
    DIR_NW = 3'd7
  } dir_t;

  // signs of the offset-free vector, carried alongside the cordic
  typedef struct packed {
    logic dx_neg;
    logic dy_pos;
    logic dy_neg;
  } quad_t;

  typedef struct packed {
    logic [15:0] raw_x;
    logic [15:0] raw_y;
  } in_item_t;

  typedef struct packed {
    logic [15:0] heading_centideg;
    logic [2:0]  direction;
  } out_item_t;

  // atan(2^-i) in units of 2^-16 degree
  function automatic ang_t atan_of(input int unsigned i);
    ang_t v;
    case (i)
      0:  v = 25'sd2949120;
      1:  v = 25'sd1740967;
      2:  v = 25'sd919879;
      3:  v = 25'sd466945;
      4:  v = 25'sd234379;
      5:  v = 25'sd117304;
      6:  v = 25'sd58666;
      7:  v = 25'sd29335;
      8:  v = 25'sd14668;
      9:  v = 25'sd7334;
      10: v = 25'sd3667;
      11: v = 25'sd1833;
      12: v = 25'sd917;
      13: v = 25'sd458;
      14: v = 25'sd229;
      15: v = 25'sd115;
      16: v = 25'sd57;
      17: v = 25'sd29;
      18: v = 25'sd14;
      19: v = 25'sd7;
      20: v = 25'sd4;
      21: v = 25'sd2;
      22: v = 25'sd1;
      default: v = 25'sd0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/core/mh_cordic.sv =====
// vectoring cordic pipeline, one micro-rotation per register stage
module mh_cordic (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  mh_pkg::mag_t  in_ax,
  input  mh_pkg::mag_t  in_ay,
  input  mh_pkg::quad_t in_quad,
  output logic          out_valid,
  output mh_pkg::ang_t  out_z,
  output mh_pkg::quad_t out_quad
);
  import mh_pkg::*;

  logic  valid_r [CORDIC_STAGES];
  cw_t   x_r     [CORDIC_STAGES];
  cw_t   y_r     [CORDIC_STAGES];
  ang_t  z_r     [CORDIC_STAGES];
  quad_t quad_r  [CORDIC_STAGES];

  genvar i;
  generate
    for (i = 0; i < CORDIC_STAGES; i++) begin : g_stage
      logic  v_in;
      cw_t   x_in;
      cw_t   y_in;
      ang_t  z_in;
      quad_t q_in;
      cw_t   x_nxt;
      cw_t   y_nxt;
      ang_t  z_nxt;

      // stage input: scaled magnitudes at the head, previous stage elsewhere
      if (i == 0) begin : g_head
        assign v_in = in_valid;
        assign x_in = cw_t'({4'b0, in_ax, {PRESHIFT{1'b0}}});
        assign y_in = cw_t'({4'b0, in_ay, {PRESHIFT{1'b0}}});
        assign z_in = '0;
        assign q_in = in_quad;
      end else begin : g_body
        assign v_in = valid_r[i-1];
        assign x_in = x_r[i-1];
        assign y_in = y_r[i-1];
        assign z_in = z_r[i-1];
        assign q_in = quad_r[i-1];
      end

      // rotate toward y = 0
      always_comb begin
        if (y_in > 0) begin
          x_nxt = x_in + (y_in >>> i);
          y_nxt = y_in - (x_in >>> i);
          z_nxt = z_in + atan_of(i);
        end else begin
          x_nxt = x_in - (y_in >>> i);
          y_nxt = y_in + (x_in >>> i);
          z_nxt = z_in - atan_of(i);
        end
      end

      // valid bit
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          valid_r[i] <= 1'b0;
        end else begin
          valid_r[i] <= v_in;
        end
      end

      // stage payload
      always_ff @(posedge clk) begin
        x_r[i]    <= x_nxt;
        y_r[i]    <= y_nxt;
        z_r[i]    <= z_nxt;
        quad_r[i] <= q_in;
      end
    end
  endgenerate

  assign out_valid = valid_r[CORDIC_STAGES-1];
  assign out_z     = z_r[CORDIC_STAGES-1];
  assign out_quad  = quad_r[CORDIC_STAGES-1];

endmodule

// ===== rtl/core/magnetometer_heading.sv =====
// top level: offset removal, cordic angle, heading with declination and compass sector
//
// Takes one transaction per clock and never raises busy; each result is
// strobed by out_valid for one cycle. Between acceptance and result lie the
// offset removal and magnitude stages, then the cordic, which spends one
// register stage on each micro-rotation, then the angle clamp, centidegree
// scaling, declination add, wrap and sector stages. Configuration writes take
// effect at once and should only be made with no transaction in flight.
module magnetometer_heading (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  mh_pkg::in_item_t  in_data,
  output logic              out_valid,
  output mh_pkg::out_item_t out_data,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [16:0]       cfg_data
);
  import mh_pkg::*;

  // configuration registers
  logic        [16:0] off_x_r;
  logic        [16:0] off_y_r;
  logic signed [15:0] decl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_x_r <= 17'd65536;
      off_y_r <= 17'd65536;
      decl_r  <= 16'sd990;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_OFFSET_SUM_X: off_x_r <= cfg_data;
        CFG_OFFSET_SUM_Y: off_y_r <= cfg_data;
        CFG_DECLINATION:  decl_r  <= signed'(cfg_data[15:0]);
        default: ;
      endcase
    end
  end

  // the pipeline never stalls
  logic accept;
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // stage a: offset removal, twice the offset-free value
  logic               a_valid_r;
  logic signed [17:0] dx_r;
  logic signed [17:0] dy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    dx_r <= signed'({1'b0, in_data.raw_x, 1'b0}) - signed'({1'b0, off_x_r});
    dy_r <= signed'({1'b0, in_data.raw_y, 1'b0}) - signed'({1'b0, off_y_r});
  end

  // stage b: magnitudes and signs
  logic  b_valid_r;
  mag_t  ax_r;
  mag_t  ay_r;
  quad_t b_quad_r;
  logic signed [17:0] ndx;
  logic signed [17:0] ndy;

  assign ndx = -dx_r;
  assign ndy = -dy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else begin
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    ax_r            <= dx_r[17] ? ndx[16:0] : dx_r[16:0];
    ay_r            <= dy_r[17] ? ndy[16:0] : dy_r[16:0];
    b_quad_r.dx_neg <= dx_r[17];
    b_quad_r.dy_pos <= !dy_r[17] && (dy_r != 18'sd0);
    b_quad_r.dy_neg <= dy_r[17];
  end

  // cordic angle
  logic  c_valid;
  ang_t  c_z;
  quad_t c_quad;

  mh_cordic u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (b_valid_r),
    .in_ax     (ax_r),
    .in_ay     (ay_r),
    .in_quad   (b_quad_r),
    .out_valid (c_valid),
    .out_z     (c_z),
    .out_quad  (c_quad)
  );

  // stage d: clamp angle to 0..90 degrees
  logic            d_valid_r;
  logic [ZC_W-1:0] zc_r;
  quad_t           d_quad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_valid_r <= 1'b0;
    end else begin
      d_valid_r <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (c_z < 0) begin
      zc_r <= '0;
    end else if (c_z > signed'({2'b0, QUARTER_Z})) begin
      zc_r <= QUARTER_Z;
    end else begin
      zc_r <= c_z[ZC_W-1:0];
    end
    d_quad_r <= c_quad;
  end

  // stage e: scale to hundredths of a degree, round half up
  logic               e_valid_r;
  logic [CENTI_W-1:0] ang_r;
  quad_t              e_quad_r;
  logic [30:0]        scaled;

  assign scaled = 31'(zc_r) * 31'd100 + 31'd32768;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_valid_r <= 1'b0;
    end else begin
      e_valid_r <= d_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    ang_r    <= scaled[29:16];
    e_quad_r <= d_quad_r;
  end

  // stage f: base heading by quadrant plus declination
  logic               f_valid_r;
  logic signed [17:0] hraw_r;
  logic        [15:0] base;

  always_comb begin
    if (e_quad_r.dx_neg) begin
      base = e_quad_r.dy_pos ? BASE_WEST - 16'(ang_r) : BASE_WEST + 16'(ang_r);
    end else begin
      base = e_quad_r.dy_neg ? BASE_EAST - 16'(ang_r) : BASE_EAST + 16'(ang_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else begin
      f_valid_r <= e_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    hraw_r <= signed'({2'b0, base}) + signed'({{2{decl_r[15]}}, decl_r});
  end

  // stage g: one wrap by a full turn, direction set by declination sign
  logic        g_valid_r;
  logic [15:0] head_r;
  logic signed [17:0] hwrap;

  always_comb begin
    hwrap = hraw_r;
    if (decl_r > 16'sd0) begin
      if (hraw_r > signed'({2'b0, FULL_TURN})) begin
        hwrap = hraw_r - signed'({2'b0, FULL_TURN});
      end
    end else begin
      if (hraw_r < 18'sd0) begin
        hwrap = hraw_r + signed'({2'b0, FULL_TURN});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_valid_r <= 1'b0;
    end else begin
      g_valid_r <= f_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= hwrap[15:0];
  end

  // stage h: compass sector and output register
  logic      out_valid_r;
  out_item_t out_r;
  dir_t      dir;

  always_comb begin
    if (head_r > TH_N_HI || head_r < TH_N_LO) begin
      dir = DIR_N;
    end else if (head_r > TH_NW) begin
      dir = DIR_NW;
    end else if (head_r > TH_W) begin
      dir = DIR_W;
    end else if (head_r > TH_SW) begin
      dir = DIR_SW;
    end else if (head_r > TH_S) begin
      dir = DIR_S;
    end else if (head_r > TH_SE) begin
      dir = DIR_SE;
    end else if (head_r > TH_E) begin
      dir = DIR_E;
    end else begin
      dir = DIR_NE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= g_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    out_r.heading_centideg <= head_r;
    out_r.direction        <= dir;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== dv/heading_checker.sv =====
// checker: predicts heading results from accepted readings and compares the result stream
module heading_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  mh_pkg::in_item_t  in_data,
  input  logic              out_valid,
  input  mh_pkg::out_item_t out_data,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [16:0]       cfg_data,
  output int                fail_count,
  output int                pending
);
  import mh_pkg::*;

  localparam int     ATAN_LEN       = 24;
  localparam int     ANGLE_PRESHIFT = 20;
  localparam longint QUARTER_TURN_Z = 64'sd5898240;
  localparam int     MAX_PRINTED    = 50;

  // a reading waiting for its result, with the heading it should produce
  typedef struct packed {
    in_item_t  reading;
    out_item_t want;
  } heading_expect_t;

  // arctangent of 2^-i in 2^-16 degree units
  longint atan_step [0:ATAN_LEN-1] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  // mirrored calibration and declination registers
  logic [16:0]        sum_x;
  logic [16:0]        sum_y;
  logic signed [15:0] decl;

  heading_expect_t heading_q [$];

  task automatic report_mismatch(string msg);
    if (fail_count < MAX_PRINTED)
      $display("[%0t] heading mismatch: %s", $realtime, msg);
    fail_count++;
  endtask

  // vectoring rotation of (ax, ay) toward the x axis, angle in centidegrees
  function automatic int cordic_centideg(longint ax, longint ay);
    longint x, y, z, xs, ys;
    if (ax == 0 && ay == 0)
      return 0;
    x = ax <<< ANGLE_PRESHIFT;
    y = ay <<< ANGLE_PRESHIFT;
    z = 0;
    for (int i = 0; i < int'(CORDIC_STAGES) && i < ATAN_LEN; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys;
        y = y - xs;
        z = z + atan_step[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - atan_step[i];
      end
    end
    if (z < 0)
      z = 0;
    if (z > QUARTER_TURN_Z)
      z = QUARTER_TURN_Z;
    return int'((z * 100 + 32768) >>> 16);
  endfunction

  // eight-way sector, a heading on a boundary falls in the lower sector, but 2250 falls in NE
  function automatic dir_t sector_of_heading(int h);
    if (h > 33750 || h < 2250) return DIR_N;
    if (h > 29250) return DIR_NW;
    if (h > 24750) return DIR_W;
    if (h > 20250) return DIR_SW;
    if (h > 15750) return DIR_S;
    if (h > 11250) return DIR_SE;
    if (h > 6750)  return DIR_E;
    return DIR_NE;
  endfunction

  function automatic out_item_t predict_heading(in_item_t rd);
    longint    rx, ry, dx, dy;
    int        angle, h;
    out_item_t res;
    rx = rd.raw_x;
    ry = rd.raw_y;
    dx = 2 * rx - longint'(sum_x);
    dy = 2 * ry - longint'(sum_y);
    angle = cordic_centideg(dx < 0 ? -dx : dx, dy < 0 ? -dy : dy);
    // base heading from the quadrant of the offset-free vector
    if (dx < 0)
      h = (dy > 0) ? 9000 - angle : 9000 + angle;
    else
      h = (dy < 0) ? 27000 - angle : 27000 + angle;
    // declination and a single wrap in the direction of its sign
    h = h + int'(decl);
    if (decl > 0) begin
      if (h > 36000)
        h = h - 36000;
    end else if (h < 0) begin
      h = h + 36000;
    end
    res.heading_centideg = h[15:0];
    res.direction        = sector_of_heading(h);
    return res;
  endfunction

  always @(posedge clk) begin : watch
    heading_expect_t entry;
    if (!rst_n) begin
      sum_x = 17'd65536;
      sum_y = 17'd65536;
      decl  = 16'sd990;
      heading_q.delete();
      fail_count = 0;
    end else begin
      // register writes
      if (cfg_we) begin
        case (cfg_index)
          CFG_OFFSET_SUM_X: sum_x = cfg_data;
          CFG_OFFSET_SUM_Y: sum_y = cfg_data;
          CFG_DECLINATION:  decl  = cfg_data[15:0];
          default: ;
        endcase
      end
      // result transaction against the oldest expectation
      if (out_valid) begin
        if (heading_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result heading %0d direction %0d",
                                    out_data.heading_centideg, out_data.direction));
        end else begin
          entry = heading_q.pop_front();
          if (out_data.heading_centideg !== entry.want.heading_centideg)
            report_mismatch($sformatf("x %0d y %0d: heading %0d, expected %0d",
                                      entry.reading.raw_x, entry.reading.raw_y,
                                      out_data.heading_centideg,
                                      entry.want.heading_centideg));
          if (out_data.direction !== entry.want.direction)
            report_mismatch($sformatf("x %0d y %0d: direction %0d, expected %0d",
                                      entry.reading.raw_x, entry.reading.raw_y,
                                      out_data.direction, entry.want.direction));
        end
      end
      // input transaction
      if (start && !busy) begin
        entry.reading = in_data;
        entry.want    = predict_heading(in_data);
        heading_q.push_back(entry);
      end
    end
    pending = heading_q.size();
  end

endmodule

// ===== dv/magnetometer_heading_test.sv =====
// testbench top: reading stimulus, register phases and verdict for the heading block
module magnetometer_heading_test;
  import mh_pkg::*;

  localparam int LATENCY         = CORDIC_STAGES + 7;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int PHASES          = 12;
  localparam int ITEMS_PER_PHASE = 88;
  localparam int CORNER_COUNT    = 15;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        start;
  logic        busy;
  in_item_t    in_data;
  logic        out_valid;
  out_item_t   out_data;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [16:0] cfg_data;

  int          fail_count;
  int          pending;
  int          idle_cycles = 0;
  logic [16:0] cur_sum_x;
  logic [16:0] cur_sum_y;

  // corner readings under the reset calibration, x in the upper half
  logic [31:0] corner_readings [0:CORNER_COUNT-1] = '{
    32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_FFFF, 32'hFFFF_0000,
    32'h8000_8000,                 // zero vector
    32'h8000_C350, 32'h8000_2710,  // x zero, y either sign
    32'hC350_8000, 32'h2710_8000,  // y zero, x either sign
    32'h9C40_9C40, 32'h4E20_9C40, 32'h9C40_4E20, 32'h4E20_4E20,
    32'h8001_8000, 32'h8000_8001
  };

  magnetometer_heading dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  heading_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // watchdog on cycles with no transaction in either direction
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("** magnetometer_heading: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // hold the reading until a rising edge accepts it; start stays high
  task automatic send_reading(in_item_t rd);
    start   <= 1'b1;
    in_data <= rd;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic pause_sender(int cycles);
    start <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  // stop sending and wait for every outstanding result
  task automatic drain_results();
    start <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  // new register setting, only with the pipeline empty
  task automatic write_settings(logic [16:0] sx, logic [16:0] sy, logic [15:0] dc);
    drain_results();
    repeat (LATENCY) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_OFFSET_SUM_X;
    cfg_data  <= sx;
    @(negedge clk);
    cfg_index <= CFG_OFFSET_SUM_Y;
    cfg_data  <= sy;
    @(negedge clk);
    cfg_index <= CFG_DECLINATION;
    cfg_data  <= {1'($urandom), dc};
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
    cur_sum_x = sx;
    cur_sum_y = sy;
  endtask

  // raw value whose doubled offset-free part is small
  function automatic logic [15:0] near_center(logic [16:0] sum, int spread);
    int c;
    c = int'(sum >> 1) + int'($urandom_range(0, 2 * spread)) - spread;
    if (c < 0)
      c = 0;
    if (c > 65535)
      c = 65535;
    return c[15:0];
  endfunction

  function automatic in_item_t random_reading();
    in_item_t rd;
    case ($urandom_range(0, 9))
      5, 6: begin
        rd.raw_x = near_center(cur_sum_x, 40);
        rd.raw_y = near_center(cur_sum_y, 40);
      end
      7: begin
        // one axis on its calibration center
        if ($urandom_range(0, 1)) begin
          rd.raw_x = near_center(cur_sum_x, 0);
          rd.raw_y = 16'($urandom);
        end else begin
          rd.raw_x = 16'($urandom);
          rd.raw_y = near_center(cur_sum_y, 0);
        end
      end
      8: begin
        rd.raw_x = near_center(cur_sum_x, 0);
        rd.raw_y = near_center(cur_sum_y, 0);
      end
      9: begin
        rd.raw_x = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        rd.raw_y = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      end
      default: begin
        rd.raw_x = 16'($urandom);
        rd.raw_y = 16'($urandom);
      end
    endcase
    return rd;
  endfunction

  initial begin
    logic quiet;
    rst_n       = 1'b0;
    start       = 1'b0;
    in_data     = '0;
    cfg_we      = 1'b0;
    cfg_index   = CFG_OFFSET_SUM_X;
    cfg_data    = '0;
    cur_sum_x   = 17'd65536;
    cur_sum_y   = 17'd65536;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int ph = 0; ph < PHASES; ph++) begin
      quiet = (ph == PHASES - 1);
      // register settings: reset values, extremes, out-of-range, boundary hits, random
      case (ph)
        0: ;
        1: write_settings(17'd0, 17'd0, 16'd0);
        2: write_settings(17'h1FFFF, 17'h1FFFF, 16'(-18000));
        3: write_settings(17'd131070, 17'd0, 16'd18000);
        4: write_settings(17'd65535, 17'd65537, 16'h7FFF);
        5: write_settings(17'd1, 17'd131069, 16'h8000);
        6: write_settings(17'd65536, 17'd65536, 16'(-6750));
        7: write_settings(17'd65536, 17'd65536, 16'd6750);
        default: write_settings(17'($urandom_range(0, 131071)),
                                17'($urandom_range(0, 131071)),
                                ($urandom_range(0, 3) == 0) ? 16'($urandom) :
                                16'(int'($urandom_range(0, 36000)) - 18000));
      endcase

      if (ph == 0) begin
        for (int k = 0; k < CORNER_COUNT; k++) begin
          if ($urandom_range(0, 3) == 0)
            pause_sender($urandom_range(1, 6));
          send_reading(in_item_t'(corner_readings[k]));
        end
      end

      repeat (ITEMS_PER_PHASE) begin
        if (!quiet && $urandom_range(0, 3) == 0)
          pause_sender($urandom_range(1, 6));
        else if (!quiet && $urandom_range(0, 63) == 0)
          drain_results();
        send_reading(random_reading());
      end
    end

    drain_results();
    repeat (LATENCY + 10) @(negedge clk);
    if (fail_count == 0 && pending == 0)
      $display("** magnetometer_heading: PASSED **");
    else
      $display("** magnetometer_heading: FAILED **");
    $finish;
  end

endmodule
